/* rtl/frm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_pkg
// Shared widths, constants and the control store of the frame rate meter.
// ----------------------------------------------------------------------------
package frm_pkg;

   localparam int STAMP_W      = 48;
   localparam int FRAME_W      = 17;
   localparam int RATE_W       = 32;
   localparam int COUNT_W      = 32;
   localparam int RATE_TOT_W   = 56;
   localparam int DIV_W        = 32;
   localparam int Q_FRAC_W     = 8;
   localparam int TDATA_REQ_W  = 48;
   localparam int TDATA_RSP_W  = 168;
   localparam int PC_W         = 4;

   localparam int WINDOW_LEN_DEFAULT = 10;
   localparam int MAX_FRAME_US       = 100000;
   localparam longint unsigned US_PER_S = 64'd1000000;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_ACCUM,
      OP_STORE_AVG,
      OP_DIV_FPS,
      OP_STORE_FPS,
      OP_ADD_RATE,
      OP_DIV_FAVG,
      OP_STORE_FAVG,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_NO_REQ,
      COND_DIV_BUSY,
      COND_OUT_FULL
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
      logic                last;
   } ctrl_word_type;

   localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
   localparam logic [PC_W-1:0] STEP_ACCUM      = 4'd1;
   localparam logic [PC_W-1:0] STEP_STORE_AVG  = 4'd2;
   localparam logic [PC_W-1:0] STEP_DIV_FPS    = 4'd3;
   localparam logic [PC_W-1:0] STEP_WAIT_FPS   = 4'd4;
   localparam logic [PC_W-1:0] STEP_STORE_FPS  = 4'd5;
   localparam logic [PC_W-1:0] STEP_ADD_RATE   = 4'd6;
   localparam logic [PC_W-1:0] STEP_DIV_FAVG   = 4'd7;
   localparam logic [PC_W-1:0] STEP_WAIT_FAVG  = 4'd8;
   localparam logic [PC_W-1:0] STEP_STORE_FAVG = 4'd9;
   localparam logic [PC_W-1:0] STEP_EMIT       = 4'd10;

   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: COND_NEXT, target: STEP_IDLE, last: 1'b1};
      case (pc)
         STEP_IDLE:       w = '{OP_CAPTURE,    COND_NO_REQ,   STEP_IDLE,      1'b0};
         STEP_ACCUM:      w = '{OP_ACCUM,      COND_NEXT,     STEP_IDLE,      1'b0};
         STEP_STORE_AVG:  w = '{OP_STORE_AVG,  COND_NEXT,     STEP_IDLE,      1'b0};
         STEP_DIV_FPS:    w = '{OP_DIV_FPS,    COND_NEXT,     STEP_IDLE,      1'b0};
         STEP_WAIT_FPS:   w = '{OP_NOP,        COND_DIV_BUSY, STEP_WAIT_FPS,  1'b0};
         STEP_STORE_FPS:  w = '{OP_STORE_FPS,  COND_NEXT,     STEP_IDLE,      1'b0};
         STEP_ADD_RATE:   w = '{OP_ADD_RATE,   COND_NEXT,     STEP_IDLE,      1'b0};
         STEP_DIV_FAVG:   w = '{OP_DIV_FAVG,   COND_NEXT,     STEP_IDLE,      1'b0};
         STEP_WAIT_FAVG:  w = '{OP_NOP,        COND_DIV_BUSY, STEP_WAIT_FAVG, 1'b0};
         STEP_STORE_FAVG: w = '{OP_STORE_FAVG, COND_NEXT,     STEP_IDLE,      1'b0};
         STEP_EMIT:       w = '{OP_EMIT,       COND_OUT_FULL, STEP_EMIT,      1'b1};
         default:         w = '{OP_NOP,        COND_NEXT,     STEP_IDLE,      1'b1};
      endcase
      return w;
   endfunction

endpackage

/* rtl/frm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module frm_div #(
   parameter int W = frm_pkg::DIV_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2*W-1:0]   dividend,
   input  logic [W-1:0]     divisor,
   output logic             busy,
   output logic [W-1:0]     quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sat_ff, sat_in;
   logic [W:0]       shifted;
   logic [W:0]       diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      sat_in = sat_ff;
      if (start) begin
         dvs_in = divisor;
         rem_in = dividend[2*W-1:W];
         quo_in = dividend[W-1:0];
         sat_in = dividend[2*W-1:W] >= divisor;
         cnt_in = (dividend[2*W-1:W] >= divisor) ? '0 : CNT_W'(W);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         sat_ff <= sat_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = sat_ff ? '1 : quo_ff;

endmodule

/* rtl/frame_rate_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_meter
// Moving-average frame rate meter run by a microcoded sequencer over one
// shared divider: frame time, window mean, Q8 rate and long-run mean rate.
// ----------------------------------------------------------------------------
// Each request makes two divisions on the shared restoring divider; a saturated
//   one skips its quotient steps. Requests are taken one at a time, after the
//   previous emit step; the next request is taken while the previous response
//   still waits, which stalls only the emit step.
// Reset: synchronous; clears the window, all totals, the pause-hold register
//   and the sequencer, which restarts at its idle step.
// ----------------------------------------------------------------------------
module frame_rate_meter #(
   parameter int WINDOW_LEN = frm_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // now_us
   input  logic [frm_pkg::TDATA_REQ_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // frame_us, avg_frame_us, fps_q8, fps_avg_q8, pause_avg_us, total_elapsed_us
   output logic [frm_pkg::TDATA_RSP_W-1:0]  rsp_tdata,
   // window_zero (frame-time sum of the window is zero)
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data
);

   localparam int STAMP_W = frm_pkg::STAMP_W;
   localparam int FRAME_W = frm_pkg::FRAME_W;
   localparam int RATE_W  = frm_pkg::RATE_W;
   localparam int COUNT_W = frm_pkg::COUNT_W;
   localparam int RTOT_W  = frm_pkg::RATE_TOT_W;
   localparam int DIV_W   = frm_pkg::DIV_W;
   localparam int QF_W    = frm_pkg::Q_FRAC_W;
   localparam int PC_W    = frm_pkg::PC_W;
   localparam int SUM_W   = FRAME_W + $clog2(WINDOW_LEN);
   localparam int PAD_W   = frm_pkg::TDATA_RSP_W - (4 * FRAME_W + 2 * RATE_W + STAMP_W) + FRAME_W;
   localparam logic [2*DIV_W-1:0] FPS_NUM =
      (2*DIV_W)'(longint'(WINDOW_LEN) * frm_pkg::US_PER_S * 256);
   localparam int RECIP_SH = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP_W  = SUM_W + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(
      ((longint'(1) << RECIP_SH) + longint'(WINDOW_LEN - 1)) / longint'(WINDOW_LEN));

   frm_pkg::ctrl_word_type ctrl;
   logic                   cond_hit;
   logic                   fire;

   logic [PC_W-1:0]        pc_ff, pc_in;
   logic                   hold_ff, hold_in;
   logic [STAMP_W-1:0]     last_ff, last_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic [FRAME_W-1:0]     win_ff [WINDOW_LEN];
   logic [FRAME_W-1:0]     win_in [WINDOW_LEN];
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [RTOT_W-1:0]      rtot_ff, rtot_in;
   logic [STAMP_W-1:0]     elapsed_ff, elapsed_in;
   logic [FRAME_W-1:0]     avg_ff, avg_in;
   logic [FRAME_W-1:0]     pause_ff, pause_in;
   logic [RATE_W-1:0]      fps_ff, fps_in;
   logic [RATE_W-1:0]      favg_ff, favg_in;
   logic                   zero_ff, zero_in;
   logic [frm_pkg::TDATA_RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [STAMP_W-1:0]     stamp_diff;
   logic [FRAME_W-1:0]     frame_clamp;
   logic [STAMP_W:0]       elapsed_sum;
   logic [RTOT_W:0]        rate_sum;
   logic [PROD_W-1:0]      avg_prod;

   logic                   div_start;
   logic [2*DIV_W-1:0]     div_dividend;
   logic [DIV_W-1:0]       div_divisor;
   logic                   div_busy;
   logic [DIV_W-1:0]       div_quot;

   frm_div #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   assign ctrl = frm_pkg::ucode(pc_ff);

   always_comb begin
      case (ctrl.cond)
         frm_pkg::COND_NEXT:     cond_hit = 1'b0;
         frm_pkg::COND_NO_REQ:   cond_hit = !req_tvalid;
         frm_pkg::COND_DIV_BUSY: cond_hit = div_busy;
         frm_pkg::COND_OUT_FULL: cond_hit = rsp_valid_ff && !rsp_tready;
         default:                cond_hit = 1'b0;
      endcase
   end

   assign fire       = !cond_hit;
   assign pc_in      = cond_hit ? ctrl.target : (ctrl.last ? '0 : pc_ff + PC_W'(1));
   assign req_tready = ctrl.cond == frm_pkg::COND_NO_REQ;
   assign hold_in    = csr_wr_en ? csr_wr_data : hold_ff;

   assign stamp_diff  = req_tdata[STAMP_W-1:0] - last_ff;
   assign frame_clamp = (stamp_diff > STAMP_W'(frm_pkg::MAX_FRAME_US)) ?
                        FRAME_W'(frm_pkg::MAX_FRAME_US) : stamp_diff[FRAME_W-1:0];
   assign elapsed_sum = {1'b0, elapsed_ff} + (STAMP_W+1)'(frame_ff);
   assign rate_sum    = {1'b0, rtot_ff} + (RTOT_W+1)'(fps_ff[RATE_W-1:QF_W]);
   assign avg_prod    = PROD_W'(sum_ff) * PROD_W'(AVG_RECIP);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = (2*DIV_W)'(sum_ff);
      div_divisor  = DIV_W'(WINDOW_LEN);
      case (ctrl.op)
         frm_pkg::OP_DIV_FPS: begin
            div_start    = fire;
            div_dividend = FPS_NUM;
            div_divisor  = (sum_ff == '0) ? DIV_W'(1) : DIV_W'(sum_ff);
         end
         frm_pkg::OP_DIV_FAVG: begin
            div_start    = fire;
            div_dividend = {rtot_ff, QF_W'(0)};
            div_divisor  = count_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      last_in      = last_ff;
      frame_in     = frame_ff;
      win_in       = win_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rtot_in      = rtot_ff;
      elapsed_in   = elapsed_ff;
      avg_in       = avg_ff;
      pause_in     = pause_ff;
      fps_in       = fps_ff;
      favg_in      = favg_ff;
      zero_in      = zero_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fire) begin
         case (ctrl.op)
            frm_pkg::OP_CAPTURE: begin
               last_in  = req_tdata[STAMP_W-1:0];
               frame_in = frame_clamp;
            end
            frm_pkg::OP_ACCUM: begin
               for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[WINDOW_LEN-1] = frame_ff;
               sum_in     = sum_ff - SUM_W'(win_ff[0]) + SUM_W'(frame_ff);
               elapsed_in = elapsed_sum[STAMP_W] ? '1 : elapsed_sum[STAMP_W-1:0];
               count_in   = (count_ff == '1) ? count_ff : count_ff + COUNT_W'(1);
            end
            frm_pkg::OP_STORE_AVG: begin
               avg_in = avg_prod[RECIP_SH +: FRAME_W];
               if (!hold_ff) begin
                  pause_in = avg_prod[RECIP_SH +: FRAME_W];
               end
            end
            frm_pkg::OP_DIV_FPS: begin
               zero_in = sum_ff == '0;
            end
            frm_pkg::OP_STORE_FPS: begin
               fps_in = div_quot;
            end
            frm_pkg::OP_ADD_RATE: begin
               rtot_in = rate_sum[RTOT_W] ? '1 : rate_sum[RTOT_W-1:0];
            end
            frm_pkg::OP_STORE_FAVG: begin
               favg_in = div_quot;
            end
            frm_pkg::OP_EMIT: begin
               rsp_data_in  = {PAD_W'(0), elapsed_ff, pause_ff, favg_ff, fps_ff,
                               avg_ff, frame_ff};
               rsp_user_in  = zero_ff;
               rsp_valid_in = 1'b1;
            end
            default: begin
               rsp_user_in = rsp_user_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= frm_pkg::STEP_IDLE;
         hold_ff      <= 1'b0;
         last_ff      <= '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff       <= '0;
         count_ff     <= '0;
         rtot_ff      <= '0;
         elapsed_ff   <= '0;
         pause_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         hold_ff      <= hold_in;
         last_ff      <= last_in;
         win_ff       <= win_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rtot_ff      <= rtot_in;
         elapsed_ff   <= elapsed_in;
         pause_ff     <= pause_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff    <= frame_in;
      avg_ff      <= avg_in;
      fps_ff      <= fps_in;
      favg_ff     <= favg_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !div_start)
      else $error("divider restarted while busy");

   a_emit_div_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && ctrl.op == frm_pkg::OP_EMIT) |-> !div_busy)
      else $error("response emitted while divider busy");

   a_req_to_accum: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> pc_ff == frm_pkg::STEP_ACCUM)
      else $error("sequencer did not advance after request");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op == frm_pkg::OP_EMIT))
      else $error("response raised outside emit step");

   a_favg_count: assert property (@(posedge clock) disable iff (reset)
      (div_start && ctrl.op == frm_pkg::OP_DIV_FAVG) |-> count_ff != '0)
      else $error("mean rate division by zero frame count");

endmodule
